// ===== src/dcrk_pkg.sv =====
// dcrk_pkg: shared constants, types and saturation helper for the dc motor rk4 step
// depends on nothing; imported by the microcode rom, the alu and the top level
package dcrk_pkg;

  // fixed point format of every word
  localparam int WORD_BITS      = 32;
  localparam int FRAC_BITS      = 16;
  localparam int TIME_STEP_BITS = 17;

  // operand width: a word or a zero-extended time step, plus a sign bit
  localparam int OPND_BITS = WORD_BITS + 1;
  localparam int PROD_BITS = 2 * OPND_BITS;
  localparam int WIDE_BITS = PROD_BITS - FRAC_BITS;

  // floor(h / 3) as (h * H3_RECIP) >> TIME_STEP_BITS, exact for every h below 2^17
  localparam int H3_BITS        = TIME_STEP_BITS - 1;
  localparam int H3_RECIP       = ((1 << TIME_STEP_BITS) + 2) / 3;
  localparam int H3_PROD_BITS   = TIME_STEP_BITS + H3_BITS;
  localparam int TIME_STEP_RST  = 66;

  // microprogram length
  localparam int UCODE_LEN = 31;
  localparam int PC_BITS   = $clog2(UCODE_LEN);

  // configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DAMPING   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DRIVE     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOAD      = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TIME_STEP = 2'd3;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_t;

  // operand sources
  typedef enum logic [4:0] {
    SRC_V, SRC_P, SRC_U, SRC_BU, SRC_K1, SRC_S2, SRC_K2, SRC_S3, SRC_K3,
    SRC_S4, SRC_K4, SRC_T, SRC_A, SRC_B, SRC_C, SRC_H, SRC_H2, SRC_H3, SRC_H6
  } src_t;

  // writable working registers
  typedef enum logic [3:0] {
    DST_V, DST_P, DST_BU, DST_K1, DST_S2, DST_K2, DST_S3, DST_K3, DST_S4,
    DST_K4, DST_T
  } dst_t;

  typedef enum logic {
    SEQ_NEXT,
    SEQ_DONE
  } seq_t;

  // one control word of the microprogram
  typedef struct packed {
    alu_op_t op;
    src_t    src_a;
    src_t    src_b;
    dst_t    dst;
    seq_t    seq;
  } ctrl_t;

  // saturated alu result
  typedef struct packed {
    word_t value;
    logic  sat;
  } alu_res_t;

  // payloads of the channels
  typedef struct packed {
    word_t drive_voltage;
  } in_req_t;

  typedef struct packed {
    word_t new_position;
    word_t new_velocity;
    logic  overflow;
  } out_req_t;

  typedef struct packed {
    logic [CFG_IDX_BITS-1:0] index;
    logic [WORD_BITS-1:0]    value;
  } cfg_req_t;

  // clamp a wide signed value to the word range and flag saturation
  function automatic alu_res_t clamp_wide(input logic signed [WIDE_BITS-1:0] v);
    alu_res_t r;
    logic [WIDE_BITS-WORD_BITS:0] upper;
    upper = v[WIDE_BITS-1:WORD_BITS-1];
    if ((&upper) || !(|upper)) begin
      r.value = v[WORD_BITS-1:0];
      r.sat   = 1'b0;
    end else begin
      r.value = v[WIDE_BITS-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                               : {1'b0, {(WORD_BITS-1){1'b1}}};
      r.sat   = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== src/dcrk_stream_if.sv =====
// dcrk_stream_if: valid/ready channel carrying one payload struct per request
// depends on nothing; payload type is given where the channel is instantiated
interface dcrk_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ===== src/dc_motor_rk4_step.sv =====
// Each request carries a drive voltage; the block advances the stored position and
// velocity by one fourth-order Runge-Kutta step of the dc motor model in signed
// Q16.16 and returns both with a saturation flag. Once a request is accepted, the
// 31-word microprogram issues one operation per cycle to the single shared multiply/add
// unit, but holds its final word while the output register is full; no new request
// is taken before it finishes. A finished result waits in the output register while
// the next request is already accepted and worked on. Configuration writes are taken
// in any cycle and must only be issued while no request is in progress.
module dc_motor_rk4_step import dcrk_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  dcrk_stream_if.sink           in_ch,
  dcrk_stream_if.source         out_ch,
  dcrk_stream_if.sink           cfg_ch
);

  // configuration registers
  word_t                       damping_r, drive_r, load_r;
  logic [TIME_STEP_BITS-1:0]   h_r;
  logic [H3_BITS-1:0]          h3_r;
  logic [H3_PROD_BITS-1:0]     h3_prod;

  // state and working registers
  word_t pos_r, vel_r, u_r, bu_r, k1_r, s2_r, k2_r, s3_r, k3_r, s4_r, k4_r, t_r;

  // sequencer
  logic               busy_r;
  logic [PC_BITS-1:0] pc_r;
  logic               sat_r;
  logic               out_valid_r;
  out_req_t           out_data_r;

  ctrl_t                       ctrl;
  alu_res_t                    alu_res;
  logic signed [OPND_BITS-1:0] opnd_a, opnd_b;
  logic                        out_free;
  logic                        step_en;
  logic                        in_take;

  dcrk_ucode_rom u_rom (
    .pc   (pc_r),
    .ctrl (ctrl)
  );

  // operand selection
  function automatic logic signed [OPND_BITS-1:0] sx(input word_t w);
    return $signed({w[WORD_BITS-1], w});
  endfunction

  function automatic logic signed [OPND_BITS-1:0] zx_h(input logic [TIME_STEP_BITS-1:0] h);
    return $signed({{(OPND_BITS-TIME_STEP_BITS){1'b0}}, h});
  endfunction

  function automatic logic signed [OPND_BITS-1:0] pick(input src_t s);
    case (s)
      SRC_V:   return sx(vel_r);
      SRC_P:   return sx(pos_r);
      SRC_U:   return sx(u_r);
      SRC_BU:  return sx(bu_r);
      SRC_K1:  return sx(k1_r);
      SRC_S2:  return sx(s2_r);
      SRC_K2:  return sx(k2_r);
      SRC_S3:  return sx(s3_r);
      SRC_K3:  return sx(k3_r);
      SRC_S4:  return sx(s4_r);
      SRC_K4:  return sx(k4_r);
      SRC_T:   return sx(t_r);
      SRC_A:   return sx(damping_r);
      SRC_B:   return sx(drive_r);
      SRC_C:   return sx(load_r);
      SRC_H:   return zx_h(h_r);
      SRC_H2:  return zx_h({1'b0, h_r[TIME_STEP_BITS-1:1]});
      SRC_H3:  return zx_h({1'b0, h3_r});
      SRC_H6:  return zx_h({2'b00, h3_r[H3_BITS-1:1]});
      default: return '0;
    endcase
  endfunction

  // operands follow both the control word and the register contents
  always_comb begin
    opnd_a = pick(ctrl.src_a);
    opnd_b = pick(ctrl.src_b);
  end

  dcrk_alu u_alu (
    .op     (ctrl.op),
    .opnd_a (opnd_a),
    .opnd_b (opnd_b),
    .res    (alu_res)
  );

  // handshakes
  assign out_free     = !out_valid_r || out_ch.ready;
  assign step_en      = busy_r && ((ctrl.seq == SEQ_NEXT) || out_free);
  assign in_ch.ready  = !busy_r;
  assign in_take      = in_ch.valid && !busy_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // floor(h / 3) for a time step request
  assign h3_prod = {{H3_BITS{1'b0}}, cfg_ch.data.value[TIME_STEP_BITS-1:0]}
                 * H3_PROD_BITS'(H3_RECIP);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damping_r <= '0;
      drive_r   <= '0;
      load_r    <= '0;
      h_r       <= TIME_STEP_BITS'(TIME_STEP_RST);
      h3_r      <= H3_BITS'(TIME_STEP_RST / 3);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        CFG_DAMPING: damping_r <= cfg_ch.data.value;
        CFG_DRIVE:   drive_r   <= cfg_ch.data.value;
        CFG_LOAD:    load_r    <= cfg_ch.data.value;
        CFG_TIME_STEP: begin
          h_r  <= cfg_ch.data.value[TIME_STEP_BITS-1:0];
          h3_r <= h3_prod[H3_PROD_BITS-1:TIME_STEP_BITS];
        end
        default: ;
      endcase
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a finished step loads the result, the sink empties it
      if (step_en && (ctrl.seq == SEQ_DONE)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_take) begin
        busy_r <= 1'b1;
        pc_r   <= '0;
        sat_r  <= 1'b0;
      end else if (step_en) begin
        sat_r <= sat_r | alu_res.sat;
        if (ctrl.seq == SEQ_DONE) begin
          busy_r <= 1'b0;
        end else begin
          pc_r <= pc_r + 1'b1;
        end
      end
    end
  end

  // result payload, loaded on the final step
  always_ff @(posedge clk) begin
    if (step_en && (ctrl.seq == SEQ_DONE)) begin
      out_data_r.new_position <= pos_r;
      out_data_r.new_velocity <= alu_res.value;
      out_data_r.overflow     <= sat_r | alu_res.sat;
    end
  end

  // plant state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      vel_r <= '0;
    end else if (step_en) begin
      if (ctrl.dst == DST_P) pos_r <= alu_res.value;
      if (ctrl.dst == DST_V) vel_r <= alu_res.value;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      u_r <= in_ch.data.drive_voltage;
    end
    if (step_en) begin
      case (ctrl.dst)
        DST_BU:  bu_r <= alu_res.value;
        DST_K1:  k1_r <= alu_res.value;
        DST_S2:  s2_r <= alu_res.value;
        DST_K2:  k2_r <= alu_res.value;
        DST_S3:  s3_r <= alu_res.value;
        DST_K3:  k3_r <= alu_res.value;
        DST_S4:  s4_r <= alu_res.value;
        DST_K4:  k4_r <= alu_res.value;
        DST_T:   t_r  <= alu_res.value;
        default: ;
      endcase
    end
  end

  // program counter stays inside the microprogram while a request is in progress
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (pc_r < PC_BITS'(UCODE_LEN)))
    else $error("microprogram counter out of range");

  // an accepted request starts at the first step
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (busy_r && (pc_r == '0) && !sat_r))
    else $error("request did not start at step zero");

  // a result appears only when the final step completes
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> (out_valid_r && $past(ctrl.seq == SEQ_DONE)))
    else $error("sequencer finished without a result");

  // a new result never overwrites one that was not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready && busy_r && (ctrl.seq == SEQ_DONE)) |=> busy_r)
    else $error("result overwritten before it was taken");

endmodule

// ===== src/dcrk_ucode_rom.sv =====
// dcrk_ucode_rom: read-only microprogram for one rk4 step, one control word per step
// depends on dcrk_pkg for the control word layout
module dcrk_ucode_rom import dcrk_pkg::*; (
  input  logic [PC_BITS-1:0] pc,
  output ctrl_t              ctrl
);

  function automatic ctrl_t uw(input alu_op_t op, input src_t a, input src_t b,
                               input dst_t d, input seq_t s);
    ctrl_t w;
    w.op    = op;
    w.src_a = a;
    w.src_b = b;
    w.dst   = d;
    w.seq   = s;
    return w;
  endfunction

  // k1..k4 velocity stages, then the weighted sums for position and velocity
  always_comb begin
    case (pc)
      5'd0:  ctrl = uw(ALU_MUL, SRC_B,  SRC_U,  DST_BU, SEQ_NEXT);
      5'd1:  ctrl = uw(ALU_MUL, SRC_A,  SRC_V,  DST_T,  SEQ_NEXT);
      5'd2:  ctrl = uw(ALU_SUB, SRC_BU, SRC_T,  DST_T,  SEQ_NEXT);
      5'd3:  ctrl = uw(ALU_SUB, SRC_T,  SRC_C,  DST_K1, SEQ_NEXT);
      5'd4:  ctrl = uw(ALU_MUL, SRC_H2, SRC_K1, DST_T,  SEQ_NEXT);
      5'd5:  ctrl = uw(ALU_ADD, SRC_V,  SRC_T,  DST_S2, SEQ_NEXT);
      5'd6:  ctrl = uw(ALU_MUL, SRC_A,  SRC_S2, DST_T,  SEQ_NEXT);
      5'd7:  ctrl = uw(ALU_SUB, SRC_BU, SRC_T,  DST_T,  SEQ_NEXT);
      5'd8:  ctrl = uw(ALU_SUB, SRC_T,  SRC_C,  DST_K2, SEQ_NEXT);
      5'd9:  ctrl = uw(ALU_MUL, SRC_H2, SRC_K2, DST_T,  SEQ_NEXT);
      5'd10: ctrl = uw(ALU_ADD, SRC_V,  SRC_T,  DST_S3, SEQ_NEXT);
      5'd11: ctrl = uw(ALU_MUL, SRC_A,  SRC_S3, DST_T,  SEQ_NEXT);
      5'd12: ctrl = uw(ALU_SUB, SRC_BU, SRC_T,  DST_T,  SEQ_NEXT);
      5'd13: ctrl = uw(ALU_SUB, SRC_T,  SRC_C,  DST_K3, SEQ_NEXT);
      5'd14: ctrl = uw(ALU_MUL, SRC_H,  SRC_K3, DST_T,  SEQ_NEXT);
      5'd15: ctrl = uw(ALU_ADD, SRC_V,  SRC_T,  DST_S4, SEQ_NEXT);
      5'd16: ctrl = uw(ALU_MUL, SRC_A,  SRC_S4, DST_T,  SEQ_NEXT);
      5'd17: ctrl = uw(ALU_SUB, SRC_BU, SRC_T,  DST_T,  SEQ_NEXT);
      5'd18: ctrl = uw(ALU_SUB, SRC_T,  SRC_C,  DST_K4, SEQ_NEXT);
      // position: p + h3*(s2 + s3) + h6*(v + s4)
      5'd19: ctrl = uw(ALU_ADD, SRC_S2, SRC_S3, DST_T,  SEQ_NEXT);
      5'd20: ctrl = uw(ALU_MUL, SRC_H3, SRC_T,  DST_T,  SEQ_NEXT);
      5'd21: ctrl = uw(ALU_ADD, SRC_P,  SRC_T,  DST_T,  SEQ_NEXT);
      5'd22: ctrl = uw(ALU_ADD, SRC_V,  SRC_S4, DST_S2, SEQ_NEXT);
      5'd23: ctrl = uw(ALU_MUL, SRC_H6, SRC_S2, DST_S2, SEQ_NEXT);
      5'd24: ctrl = uw(ALU_ADD, SRC_T,  SRC_S2, DST_P,  SEQ_NEXT);
      // velocity: v + h3*(k2 + k3) + h6*(k1 + k4)
      5'd25: ctrl = uw(ALU_ADD, SRC_K2, SRC_K3, DST_T,  SEQ_NEXT);
      5'd26: ctrl = uw(ALU_MUL, SRC_H3, SRC_T,  DST_T,  SEQ_NEXT);
      5'd27: ctrl = uw(ALU_ADD, SRC_V,  SRC_T,  DST_T,  SEQ_NEXT);
      5'd28: ctrl = uw(ALU_ADD, SRC_K1, SRC_K4, DST_K1, SEQ_NEXT);
      5'd29: ctrl = uw(ALU_MUL, SRC_H6, SRC_K1, DST_K1, SEQ_NEXT);
      5'd30: ctrl = uw(ALU_ADD, SRC_T,  SRC_K1, DST_V,  SEQ_DONE);
      default: ctrl = uw(ALU_ADD, SRC_T, SRC_T, DST_T, SEQ_DONE);
    endcase
  end

endmodule

// ===== src/dcrk_alu.sv =====
// dcrk_alu: shared saturating add, subtract and fixed point multiply
// depends on dcrk_pkg for widths and the clamp helper
module dcrk_alu import dcrk_pkg::*; (
  input  alu_op_t                      op,
  input  logic signed [OPND_BITS-1:0]  opnd_a,
  input  logic signed [OPND_BITS-1:0]  opnd_b,
  output alu_res_t                     res
);

  logic signed [PROD_BITS-1:0] prod;
  logic signed [WIDE_BITS-1:0] a_ext;
  logic signed [WIDE_BITS-1:0] b_ext;
  logic signed [WIDE_BITS-1:0] wide;

  // full product, then drop the fraction bits (floor)
  assign prod  = opnd_a * opnd_b;
  assign a_ext = $signed({{(WIDE_BITS-OPND_BITS){opnd_a[OPND_BITS-1]}}, opnd_a});
  assign b_ext = $signed({{(WIDE_BITS-OPND_BITS){opnd_b[OPND_BITS-1]}}, opnd_b});

  always_comb begin
    case (op)
      ALU_MUL: wide = $signed(prod[PROD_BITS-1:FRAC_BITS]);
      ALU_SUB: wide = a_ext - b_ext;
      default: wide = a_ext + b_ext;
    endcase
  end

  // saturate to the word range
  assign res = clamp_wide(wide);

endmodule

// ===== tb/dcrk_step_checker.sv =====
`timescale 1ns / 1ps
// dcrk_step_checker: watches the three channels of the rk4 motor step, predicts each result
// and compares it field by field; depends on dcrk_pkg for payload types and register indexes
module dcrk_step_checker import dcrk_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  in_req_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  out_req_t out_data,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  cfg_req_t cfg_data,
  output int       pending,
  output int       fail_count
);

  localparam longint WORD_HI = (longint'(1) << (WORD_BITS - 1)) - 1;
  localparam longint WORD_LO = -WORD_HI - 1;

  // own copy of the coefficients and the plant state
  longint   damp_a;
  longint   gain_b;
  longint   load_c;
  longint   step_h;
  longint   motor_pos;
  longint   motor_vel;
  bit       step_sat;
  out_req_t predicted_steps[$];

  // clamp to the word range, noting any saturation of this step
  function automatic longint clip_word(input longint v);
    if (v > WORD_HI) begin
      step_sat = 1'b1;
      return WORD_HI;
    end
    if (v < WORD_LO) begin
      step_sat = 1'b1;
      return WORD_LO;
    end
    return v;
  endfunction

  function automatic longint fx_add(input longint x, input longint y);
    return clip_word(x + y);
  endfunction

  function automatic longint fx_sub(input longint x, input longint y);
    return clip_word(x - y);
  endfunction

  // operands never exceed 2^31 by 2^31, so the full product fits; shift floors
  function automatic longint fx_mul(input longint x, input longint y);
    longint p;
    p = x * y;
    return clip_word(p >>> FRAC_BITS);
  endfunction

  // velocity derivative: b*u - a*w - c
  function automatic longint motor_accel(input longint w, input longint u);
    return fx_sub(fx_sub(fx_mul(gain_b, u), fx_mul(damp_a, w)), load_c);
  endfunction

  // one classical rk4 step; updates the state and returns the result
  function automatic out_req_t rk4_advance(input word_t drive);
    longint   u, h2, h3, h6;
    longint   k1, s2, k2, s3, k3, s4, k4, np, nv;
    out_req_t r;
    step_sat = 1'b0;
    u  = drive;
    h2 = step_h / 2;
    h3 = step_h / 3;
    h6 = step_h / 6;
    k1 = motor_accel(motor_vel, u);
    s2 = fx_add(motor_vel, fx_mul(h2, k1));
    k2 = motor_accel(s2, u);
    s3 = fx_add(motor_vel, fx_mul(h2, k2));
    k3 = motor_accel(s3, u);
    s4 = fx_add(motor_vel, fx_mul(step_h, k3));
    k4 = motor_accel(s4, u);
    np = fx_add(fx_add(motor_pos, fx_mul(h3, fx_add(s2, s3))),
                fx_mul(h6, fx_add(motor_vel, s4)));
    nv = fx_add(fx_add(motor_vel, fx_mul(h3, fx_add(k2, k3))),
                fx_mul(h6, fx_add(k1, k4)));
    motor_pos = np;
    motor_vel = nv;
    r.new_position = np[WORD_BITS-1:0];
    r.new_velocity = nv[WORD_BITS-1:0];
    r.overflow     = step_sat;
    return r;
  endfunction

  // sample every channel at the clock edge
  always @(posedge clk) begin : watch
    out_req_t want;
    if (!rst_n) begin
      damp_a     = 0;
      gain_b     = 0;
      load_c     = 0;
      step_h     = TIME_STEP_RST;
      motor_pos  = 0;
      motor_vel  = 0;
      fail_count = 0;
      predicted_steps.delete();
      pending <= 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_data.index)
          CFG_DAMPING:   damp_a = $signed(cfg_data.value);
          CFG_DRIVE:     gain_b = $signed(cfg_data.value);
          CFG_LOAD:      load_c = $signed(cfg_data.value);
          CFG_TIME_STEP: step_h = cfg_data.value[TIME_STEP_BITS-1:0];
          default: ;
        endcase
      end
      // drive voltage requests
      if (in_valid && in_ready)
        predicted_steps.push_back(rk4_advance(in_data.drive_voltage));
      // results
      if (out_valid && out_ready) begin
        if (predicted_steps.size() == 0) begin
          $error("result with no request outstanding: pos %0d vel %0d ovf %0b",
                 out_data.new_position, out_data.new_velocity, out_data.overflow);
          fail_count++;
        end else begin
          want = predicted_steps.pop_front();
          if (out_data.new_position !== want.new_position) begin
            $error("new_position: expected %0d, actual %0d",
                   want.new_position, out_data.new_position);
            fail_count++;
          end
          if (out_data.new_velocity !== want.new_velocity) begin
            $error("new_velocity: expected %0d, actual %0d",
                   want.new_velocity, out_data.new_velocity);
            fail_count++;
          end
          if (out_data.overflow !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow, out_data.overflow);
            fail_count++;
          end
        end
      end
      pending <= predicted_steps.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench: drives drive voltage requests and register writes into dc_motor_rk4_step
// under several idling patterns; depends on dcrk_pkg, dcrk_stream_if and dcrk_step_checker
module testbench;
  import dcrk_pkg::*;

  localparam int          IDLE_LIMIT   = 4000;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          PHASES       = 16;
  localparam int          PHASE_ITEMS  = 105;
  localparam logic [31:0] WORD_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] WORD_MIN     = 32'h8000_0000;

  logic clk = 1'b0;
  logic rst_n;
  int   pending;
  int   fail_count;
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  int   hold_requests = 0;
  int   holds_taken = 0;
  int   hold_left = 0;
  int   idle_cycles = 0;

  dcrk_stream_if #(.payload_t(in_req_t))  in_ch ();
  dcrk_stream_if #(.payload_t(out_req_t)) out_ch ();
  dcrk_stream_if #(.payload_t(cfg_req_t)) cfg_ch ();

  always #2 clk = ~clk;

  dc_motor_rk4_step dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  dcrk_step_checker step_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_data    (in_ch.data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_ch.data),
    .cfg_valid  (cfg_ch.valid),
    .cfg_ready  (cfg_ch.ready),
    .cfg_data   (cfg_ch.data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // result side: random stalls, plus a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (holds_taken != hold_requests) begin
      holds_taken = hold_requests;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // watchdog on cycles in which no request moves on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $error("watchdog: nothing accepted for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // offer one drive voltage, possibly after a gap, and wait for acceptance
  task automatic send_voltage(input logic [31:0] u);
    int gap;
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 40);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data.drive_voltage <= u;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering and wait for every outstanding result
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.value <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // rewrite all coefficients once the block has gone idle
  task automatic program_regs(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input logic [31:0] h);
    settle();
    write_reg(CFG_DAMPING, a);
    write_reg(CFG_DRIVE, b);
    write_reg(CFG_LOAD, c);
    write_reg(CFG_TIME_STEP, h);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [31:0] u;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients: everything stays at rest
    send_voltage(WORD_MAX);
    send_voltage(WORD_MIN);

    // a moderate plant
    program_regs(32'h0002_0000, 32'h0001_8000, 32'h0000_4000, 32'h0000_0CCD);
    send_voltage(32'd0);
    send_voltage(32'd1);
    send_voltage(32'hFFFF_FFFF);
    send_voltage(32'h0001_0000);
    send_voltage(32'hFFFF_0000);
    send_voltage(WORD_MAX);
    send_voltage(WORD_MIN);

    // zero time step leaves the state where it is
    program_regs(32'd0, 32'h0001_0000, 32'd0, 32'd0);
    send_voltage(32'h0005_0000);
    send_voltage(32'hFFFF_FFFD);

    // time step beyond one second, upper bits of the write ignored
    program_regs(32'h0000_8000, 32'hFFFF_0000, 32'hFFFF_8000, 32'hFFFF_FFFF);
    send_voltage(32'h0003_0000);
    send_voltage(32'hFFFD_0000);
    send_voltage(32'd5);

    // coefficient extremes, saturating hard
    program_regs(WORD_MAX, WORD_MIN, WORD_MAX, 32'h0001_0000);
    send_voltage(WORD_MAX);
    send_voltage(WORD_MIN);
    send_voltage(32'd0);
    program_regs(WORD_MIN, WORD_MAX, WORD_MIN, 32'd1);
    send_voltage(WORD_MIN);
    send_voltage(WORD_MAX);
    send_voltage(32'hFFFF_FFFF);

    // tiny negative damping: products with a remainder round towards minus infinity
    program_regs(32'hFFFF_FFFF, 32'd3, 32'd1, 32'd7);
    send_voltage(32'hFFFF_FFF9);
    send_voltage(32'd7);
    send_voltage(32'h0001_2345);

    // random phases under the four idling patterns
    for (int p = 0; p < PHASES; p++) begin
      settle();
      tx_idle_pct  = (p % 4 == 1) ? 51 : (p % 4 == 3) ? 21 : 0;
      rx_stall_pct = (p % 4 == 2) ? 51 : (p % 4 == 3) ? 21 : 0;
      if (p == 5)
        program_regs(WORD_MAX, WORD_MAX, WORD_MAX, 32'h0001_FFFF);
      else if (p == 10)
        program_regs(WORD_MIN, WORD_MIN, WORD_MIN, 32'd1);
      else if (p % 7 == 3)
        program_regs($urandom(), $urandom(), $urandom(), $urandom());
      else
        program_regs($urandom_range(0, 32'h8_0000),
                     $urandom_range(0, 32'h8_0000) - 32'h4_0000,
                     $urandom_range(0, 32'h2_0000) - 32'h1_0000,
                     ($urandom() & ~32'h1_FFFF) | $urandom_range(1, 32'h2000));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p % 4 == 2 && n == 20)
          hold_requests <= hold_requests + 1;
        if ($urandom_range(0, 49) == 0)
          settle();
        if ($urandom_range(99) < 85)
          u = $urandom_range(0, 32'h30_0000) - 32'h18_0000;
        else
          u = $urandom();
        send_voltage(u);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== dc_motor_rk4_step.f =====
src/dcrk_pkg.sv
src/dcrk_stream_if.sv
src/dcrk_ucode_rom.sv
src/dcrk_alu.sv
src/dc_motor_rk4_step.sv
tb/dcrk_step_checker.sv
tb/testbench.sv
